// ----- sv/cmavg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cmavg_pkg;

   localparam int MAX_HALF_WINDOW = 15;
   localparam int NUM_COLUMNS     = 4;
   localparam int SAMPLE_BITS     = 24;

   localparam int WIN_DEPTH    = 2 * MAX_HALF_WINDOW + 1;
   localparam int HW_BITS      = $clog2(MAX_HALF_WINDOW + 1);
   localparam int LEN_BITS     = $clog2(WIN_DEPTH + 1);
   localparam int SLOT_BITS    = $clog2(WIN_DEPTH);
   localparam int COL_BITS     = $clog2(NUM_COLUMNS + 1);
   localparam int COL_IDX_BITS = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int SUM_BITS     = SAMPLE_BITS + $clog2(WIN_DEPTH);
   localparam int RECIP_BITS   = SUM_BITS + 1;
   localparam int ROW_BITS     = NUM_COLUMNS * SAMPLE_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // control register file
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 4;
   localparam int HALF_WINDOW_BITS = 4;
   localparam int COLUMNS_BITS     = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_WINDOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMNS_IN_USE = 2'd1;

   localparam logic [HALF_WINDOW_BITS-1:0] HALF_WINDOW_RESET = 4'd2;
   localparam logic [COLUMNS_BITS-1:0]     COLUMNS_RESET     = 3'd4;

   typedef logic [NUM_COLUMNS-1:0][SAMPLE_BITS-1:0] row_type;

   typedef struct packed {
      logic [HW_BITS-1:0]  hw;
      logic [LEN_BITS-1:0] len;
      logic [COL_BITS-1:0] cols;
   } cfg_type;

   typedef struct packed {
      logic                 clr;
      logic                 evict;
      logic                 emit;
      logic [SLOT_BITS-1:0] slot;
      row_type              row;
   } work_type;

   typedef struct packed {
      logic                        valid;
      logic [COL_IDX_BITS-1:0]     col;
      logic signed [SUM_BITS-1:0]  sum;
   } div_req_type;

   typedef struct packed {
      logic                    valid;
      logic [COL_IDX_BITS-1:0] col;
      logic [SAMPLE_BITS-1:0]  quot;
   } div_rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ACCUM,
      BK_DIV
   } back_state_type;

endpackage

`default_nettype wire

// ----- sv/cmavg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmavg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/cmavg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmavg_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cmavg_pkg::work_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output cmavg_pkg::work_type      head,
   output logic                     empty
);
   import cmavg_pkg::*;

   work_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- sv/cmavg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmavg_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmavg_pkg::cfg_type cfg,
   input  wire logic               csr_write,
   input  wire logic               req_valid,
   input  wire logic               req_first_row,
   input  wire cmavg_pkg::row_type req_row,
   input  wire logic               q_full,
   output logic                    req_stall,
   output logic                    push,
   output cmavg_pkg::work_type     push_data
);
   import cmavg_pkg::*;

   logic [LEN_BITS-1:0]  fill_ff, fill_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 pend_clr_ff;

   logic                 clr;
   logic [LEN_BITS-1:0]  fill_base;
   logic [LEN_BITS-1:0]  fill_inc;
   logic [LEN_BITS-1:0]  slot_base;
   logic [LEN_BITS-1:0]  slot_cur;
   logic [LEN_BITS-1:0]  slot_inc;
   logic                 evict;

   always_comb begin
      clr       = req_first_row | pend_clr_ff;
      fill_base = clr ? '0 : fill_ff;
      slot_base = clr ? '0 : LEN_BITS'(slot_ff);
      slot_cur  = (slot_base >= cfg.len) ? '0 : slot_base;
      evict     = (fill_base >= cfg.len);
      fill_inc  = fill_base + 1'b1;
      fill_in   = evict ? cfg.len : fill_inc;
      slot_inc  = slot_cur + 1'b1;
      slot_in   = SLOT_BITS'((slot_inc >= cfg.len) ? '0 : slot_inc);

      push_data.clr   = clr;
      push_data.evict = evict;
      push_data.emit  = evict | (fill_inc >= cfg.len);
      push_data.slot  = SLOT_BITS'(slot_cur);
      // inactive columns are stored as zero
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         push_data.row[c] = (COL_BITS'(c) < cfg.cols) ? req_row[c] : '0;
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         slot_ff     <= '0;
         pend_clr_ff <= 1'b0;
      end else if (csr_write) begin
         fill_ff     <= '0;
         slot_ff     <= '0;
         pend_clr_ff <= 1'b1;
      end else if (push) begin
         fill_ff     <= fill_in;
         slot_ff     <= slot_in;
         pend_clr_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- sv/cmavg_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmavg_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmavg_pkg::cfg_type     cfg,
   input  wire cmavg_pkg::div_req_type req,
   output cmavg_pkg::div_rsp_type      rsp
);
   import cmavg_pkg::*;

   localparam int PROD_BITS = SUM_BITS + RECIP_BITS;
   localparam longint unsigned RECIP_NUM = (64'd1 << RECIP_BITS) - 64'd1;

   // floor((2^k - 1) / len) for each window length
   logic [RECIP_BITS-1:0] recip_tab [MAX_HALF_WINDOW + 1];

   for (genvar h = 0; h <= MAX_HALF_WINDOW; h++) begin : g_recip
      localparam longint unsigned RECIP = RECIP_NUM / (2 * h + 1);
      assign recip_tab[h] = RECIP_BITS'(RECIP);
   end

   logic                    v1_ff, v2_ff, v3_ff;
   logic [COL_IDX_BITS-1:0] col1_ff, col2_ff, col3_ff;
   logic                    neg1_ff, neg2_ff;
   logic [SUM_BITS-1:0]     mag1_ff, mag2_ff, mag_in;
   logic [LEN_BITS-1:0]     len1_ff, len2_ff;
   logic [RECIP_BITS-1:0]   recip1_ff;
   logic [PROD_BITS-1:0]    prod2_ff, prod_in;
   logic [SAMPLE_BITS-1:0]  quot3_ff, quot_in;

   logic [SUM_BITS-1:0]     q0;
   logic [SUM_BITS-1:0]     qlen;
   logic [SUM_BITS-1:0]     rem;
   logic [SUM_BITS-1:0]     q;

   always_comb begin
      mag_in  = req.sum[SUM_BITS-1] ? (~req.sum + 1'b1) : req.sum;
      prod_in = PROD_BITS'(mag1_ff) * PROD_BITS'(recip1_ff);

      // estimate is exact or one low
      q0      = prod2_ff[PROD_BITS-1:RECIP_BITS];
      qlen    = SUM_BITS'(q0 * SUM_BITS'(len2_ff));
      rem     = mag2_ff - qlen;
      q       = (rem >= SUM_BITS'(len2_ff)) ? q0 + 1'b1 : q0;
      quot_in = SAMPLE_BITS'(neg2_ff ? (~q + 1'b1) : q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      col1_ff   <= req.col;
      neg1_ff   <= req.sum[SUM_BITS-1];
      mag1_ff   <= mag_in;
      len1_ff   <= cfg.len;
      recip1_ff <= recip_tab[cfg.hw];

      col2_ff   <= col1_ff;
      neg2_ff   <= neg1_ff;
      mag2_ff   <= mag1_ff;
      len2_ff   <= len1_ff;
      prod2_ff  <= prod_in;

      col3_ff   <= col2_ff;
      quot3_ff  <= quot_in;
   end

   assign rsp.valid = v3_ff;
   assign rsp.col   = col3_ff;
   assign rsp.quot  = quot3_ff;

endmodule

`default_nettype wire

// ----- sv/cmavg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmavg_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmavg_pkg::cfg_type  cfg,
   input  wire logic                q_empty,
   input  wire cmavg_pkg::work_type q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output cmavg_pkg::row_type       rsp_avg
);
   import cmavg_pkg::*;

   back_state_type             state_ff, state_in;
   work_type                   item_ff;
   logic signed [SUM_BITS-1:0] sums_ff [NUM_COLUMNS];
   logic signed [SUM_BITS-1:0] sums_in [NUM_COLUMNS];
   logic [COL_IDX_BITS-1:0]    col_ff;
   logic                       out_busy_ff;
   logic                       rsp_valid_ff;
   row_type                    avg_ff;

   logic                       ram_wr_en;
   row_type                    ram_rd_data;
   logic                       issue;
   logic                       last_col;
   logic                       rsp_take;
   div_req_type                div_req;
   div_rsp_type                div_rsp;

   function automatic logic signed [SUM_BITS-1:0] sext(input logic [SAMPLE_BITS-1:0] s);
      sext = {{(SUM_BITS - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
   endfunction

   cmavg_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (WIN_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (item_ff.slot),
      .wr_data (item_ff.row),
      .rd_en   (q_pop),
      .rd_addr (q_head.slot),
      .rd_data (ram_rd_data)
   );

   cmavg_div u_div (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign last_col = (col_ff == COL_IDX_BITS'(NUM_COLUMNS - 1));
   assign rsp_take = rsp_valid_ff & ~rsp_stall;

   // outputs of the sequencer
   always_comb begin
      q_pop     = 1'b0;
      ram_wr_en = 1'b0;
      issue     = 1'b0;
      case (state_ff)
         BK_IDLE:  q_pop     = ~q_empty;
         BK_ACCUM: ram_wr_en = 1'b1;
         // first column waits until the previous result has left
         BK_DIV:   issue     = (col_ff != '0) | ~out_busy_ff;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (!q_empty) state_in = BK_ACCUM;
         BK_ACCUM: state_in = item_ff.emit ? BK_DIV : BK_IDLE;
         BK_DIV:   if (issue && last_col) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         sums_in[c] = (item_ff.clr ? '0 : sums_ff[c])
                    - (item_ff.evict ? sext(ram_rd_data[c]) : '0)
                    + sext(item_ff.row[c]);
      end
   end

   assign div_req.valid = issue;
   assign div_req.col   = col_ff;
   assign div_req.sum   = sums_ff[col_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         col_ff       <= '0;
         out_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            sums_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_ACCUM) begin
            sums_ff <= sums_in;
         end
         if (issue) begin
            col_ff <= last_col ? '0 : col_ff + 1'b1;
         end
         if (issue && col_ff == '0) begin
            out_busy_ff <= 1'b1;
         end else if (rsp_take) begin
            out_busy_ff <= 1'b0;
         end
         if (div_rsp.valid && div_rsp.col == COL_IDX_BITS'(NUM_COLUMNS - 1)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_head;
      end
      if (div_rsp.valid) begin
         avg_ff[div_rsp.col] <= div_rsp.quot;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_avg   = avg_ff;

endmodule

`default_nettype wire

// ----- sv/centered_moving_average.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_first_row, req_sample_0..3
// rsp       out        rsp_valid / rsp_stall  rsp_avg_0..3
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// a row passes the back end's window read and sum update; a row that
// yields a mean then feeds its columns through the 3-stage reciprocal
// divide, and its first column waits until the last result is taken. the
// back end pops the next row only once it is done with the current one.
// reset clears control state and the column sums; the window ram needs no clear.
// a 2-entry queue parts front and back; a held result stalls only the next divide.

module centered_moving_average (
   input  wire logic                                      clock,
   input  wire logic                                      reset,

   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic                                      req_first_row,
   input  wire logic signed [cmavg_pkg::SAMPLE_BITS-1:0]  req_sample_0,
   input  wire logic signed [cmavg_pkg::SAMPLE_BITS-1:0]  req_sample_1,
   input  wire logic signed [cmavg_pkg::SAMPLE_BITS-1:0]  req_sample_2,
   input  wire logic signed [cmavg_pkg::SAMPLE_BITS-1:0]  req_sample_3,

   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic signed [cmavg_pkg::SAMPLE_BITS-1:0]       rsp_avg_0,
   output logic signed [cmavg_pkg::SAMPLE_BITS-1:0]       rsp_avg_1,
   output logic signed [cmavg_pkg::SAMPLE_BITS-1:0]       rsp_avg_2,
   output logic signed [cmavg_pkg::SAMPLE_BITS-1:0]       rsp_avg_3,

   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [cmavg_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [cmavg_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);
   import cmavg_pkg::*;

   logic [HALF_WINDOW_BITS-1:0] half_window_ff;
   logic [COLUMNS_BITS-1:0]     columns_ff;
   logic                        csr_write;
   cfg_type                     cfg;

   row_type  req_row;
   row_type  rsp_avg;
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   work_type push_data;
   work_type q_head;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready
                    & ((csr_index == CSR_HALF_WINDOW) || (csr_index == CSR_COLUMNS_IN_USE));

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff <= HALF_WINDOW_RESET;
         columns_ff     <= COLUMNS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_WINDOW:    half_window_ff <= HALF_WINDOW_BITS'(csr_wdata);
            CSR_COLUMNS_IN_USE: columns_ff     <= COLUMNS_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(half_window_ff) > MAX_HALF_WINDOW) begin
         cfg.hw = HW_BITS'(MAX_HALF_WINDOW);
      end else begin
         cfg.hw = HW_BITS'(half_window_ff);
      end
      cfg.len = LEN_BITS'({cfg.hw, 1'b1});
      if (columns_ff == '0) begin
         cfg.cols = COL_BITS'(1);
      end else if (32'(columns_ff) > NUM_COLUMNS) begin
         cfg.cols = COL_BITS'(NUM_COLUMNS);
      end else begin
         cfg.cols = COL_BITS'(columns_ff);
      end
   end

   assign req_row[0] = req_sample_0;
   assign req_row[1] = req_sample_1;
   assign req_row[2] = req_sample_2;
   assign req_row[3] = req_sample_3;

   assign rsp_avg_0 = rsp_avg[0];
   assign rsp_avg_1 = rsp_avg[1];
   assign rsp_avg_2 = rsp_avg[2];
   assign rsp_avg_3 = rsp_avg[3];

   cmavg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .csr_write     (csr_write),
      .req_valid     (req_valid),
      .req_first_row (req_first_row),
      .req_row       (req_row),
      .q_full        (q_full),
      .req_stall     (req_stall),
      .push          (q_push),
      .push_data     (push_data)
   );

   cmavg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   cmavg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_avg   (rsp_avg)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("request pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("back end popped an empty queue");

   a_len_odd_in_range: assert property (@(posedge clock) disable iff (reset)
      cfg.len[0] && (32'(cfg.len) <= WIN_DEPTH))
      else $error("window length out of range");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !q_full))
      else $error("result or full queue right after reset");

endmodule

`default_nettype wire
